// File: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the 3x3 local binary pattern core.
// ----------------------------------------------------------------------------
package lbp_pkg;

	// Field widths
	localparam int PIXEL_W      = 8;
	localparam int CODE_W       = 8;
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Item actions
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Frame geometry limits and reset values
	localparam int                      WIDTH_RESET  = 640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

	// Output queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = 2;
	localparam int OFIFO_CNT_W = 3;

	typedef struct packed {
		logic               action;
		logic [PIXEL_W-1:0] pixel;
	} pix_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] lbp_code;
		logic              last_of_frame;
	} code_item_t;

	// Neighbor masks and code control for one window step
	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} lbp_flags_t;

endpackage

// File: rtl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Generic single-clock RAM, one write port and one read port, registered read
// (read-first on an address collision).
// ----------------------------------------------------------------------------
module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/lbp_code_unit.sv
// ----------------------------------------------------------------------------
// lbp_code_unit
// Window columns and neighbor compare: forms one pattern code per window step
// and shifts the incoming column into the window.
// ----------------------------------------------------------------------------
module lbp_code_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv_v,
	input  lbp_pkg::lbp_flags_t            flags,
	input  logic [lbp_pkg::PIXEL_W-1:0]    col_up,
	input  logic [lbp_pkg::PIXEL_W-1:0]    col_mid,
	input  logic [lbp_pkg::PIXEL_W-1:0]    col_pix,
	output logic                           code_v,
	output lbp_pkg::code_item_t            code_item
);

	// Two newest window columns, index 0 top, 1 middle, 2 bottom
	logic [lbp_pkg::PIXEL_W-1:0] win1_q [3];
	logic [lbp_pkg::PIXEL_W-1:0] win2_q [3];
	logic [lbp_pkg::PIXEL_W-1:0] ctr;
	logic [lbp_pkg::CODE_W-1:0]  code;

	// Compare neighbors against the centre, MSB first from top-left clockwise
	always_comb begin
		ctr     = win2_q[1];
		code[7] = flags.top && flags.left && (win1_q[0] >= ctr);
		code[6] = flags.top && (win2_q[0] >= ctr);
		code[5] = flags.top && flags.right && (col_up >= ctr);
		code[4] = flags.right && (col_mid >= ctr);
		code[3] = flags.bottom && flags.right && (col_pix >= ctr);
		code[2] = flags.bottom && (win2_q[2] >= ctr);
		code[1] = flags.bottom && flags.left && (win1_q[2] >= ctr);
		code[0] = flags.left && (win1_q[1] >= ctr);
	end

	assign code_v                  = adv_v && flags.emit;
	assign code_item.lbp_code      = code;
	assign code_item.last_of_frame = flags.last;

	// Shift the new column in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= '0;
				win2_q[i] <= '0;
			end
		end else if (adv_v) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= win2_q[i];
			end
			win2_q[0] <= col_up;
			win2_q[1] <= col_mid;
			win2_q[2] <= col_pix;
		end
	end

endmodule

// File: rtl/lbp_out_fifo.sv
// ----------------------------------------------------------------------------
// lbp_out_fifo
// Small result queue in front of the code channel; decouples the window
// pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
module lbp_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  lbp_pkg::code_item_t               push_item,
	output logic [lbp_pkg::OFIFO_CNT_W-1:0]   count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lbp_pkg::code_item_t               out_item
);

	lbp_pkg::code_item_t                mem_q [lbp_pkg::OFIFO_DEPTH];
	logic [lbp_pkg::OFIFO_PTR_W-1:0]    wr_ptr_q;
	logic [lbp_pkg::OFIFO_PTR_W-1:0]    rd_ptr_q;
	logic [lbp_pkg::OFIFO_CNT_W-1:0]    cnt_q;
	logic                               pop;

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign count     = cnt_q;
	assign pop       = out_valid && !out_stall;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The upstream room check must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != lbp_pkg::OFIFO_CNT_W'(lbp_pkg::OFIFO_DEPTH))
		else $error("lbp_out_fifo: push into full queue");

endmodule

// File: rtl/lbp_3x3_operator_core.sv
// ----------------------------------------------------------------------------
// lbp_3x3_operator_core
// Basic 3x3 local binary pattern over a raster pixel stream.
//
// Pixel channel (pix_valid / pix_stall / pix_item): action 0 pushes a pixel,
// action 1 drains one pending code once the frame's last pixel is in.
// Code channel (code_valid / code_stall / code_item): one 8-bit code per
// pixel in raster order, last_of_frame marks the final code of the frame.
// Config channel (cfg_valid / cfg_ready): index 0 image width, 1 image height;
// a write restarts the frame. Write only while the core is idle.
// Throughput: one transaction per cycle while pix_stall is low. The column
// store is one RAM word per column, read at issue and written back in the
// next cycle, with a bypass for back-to-back steps on the same column. A
// drain in a one-row frame that needs two window steps holds pix_stall
// until the second step issues. A code passes stage 1 and the result queue
// after the transaction that completes its neighborhood (one row plus one
// pixel after its centre pixel). Reset: positions return to zero, then a
// clearing pass writes zeros to all MAX_WIDTH column entries under pix_stall.
// When code_stall is held, results collect in a four-entry queue and
// pix_stall rises once no room is left for the transactions in flight.
// ----------------------------------------------------------------------------
module lbp_3x3_operator_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Pixel channel
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  lbp_pkg::pix_item_t                  pix_item,
	// Code channel
	output logic                                code_valid,
	input  logic                                code_stall,
	output lbp_pkg::code_item_t                 code_item,
	// Config channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW        = $clog2(MAX_WIDTH);
	localparam int WIDTH_RST = (lbp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH :
		lbp_pkg::WIDTH_RESET;
	localparam int WORD_W    = 2 * lbp_pkg::PIXEL_W;

	// Geometry and position
	logic [lbp_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [lbp_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [lbp_pkg::CFG_HEIGHT_W-1:0] row_q;
	logic [AW-1:0]                    col_q;
	logic                             extra_q;
	logic                             clr_busy_q;
	logic [AW-1:0]                    clr_addr_q;

	// Stage 1
	logic                             adv_s1;
	logic [AW-1:0]                    addr_s1;
	logic [lbp_pkg::PIXEL_W-1:0]      pix_s1;
	lbp_pkg::lbp_flags_t              flags_s1;

	// Last RAM write, for the read bypass
	logic                             wr_v_q;
	logic [AW-1:0]                    wr_addr_q;
	logic [WORD_W-1:0]                wr_data_q;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [WORD_W-1:0]                ram_wdata;
	logic [WORD_W-1:0]                ram_rdata;
	logic [WORD_W-1:0]                col_word;

	logic [lbp_pkg::OFIFO_CNT_W-1:0]  fifo_cnt;
	logic                             res_v;
	lbp_pkg::code_item_t              res_item;

	logic                             cfg_we;
	logic [lbp_pkg::CFG_WIDTH_W-1:0]  width_nxt;
	logic [lbp_pkg::CFG_HEIGHT_W-1:0] height_nxt;
	logic                             room;
	logic                             accept;
	logic                             is_push;
	logic                             in_range;
	logic                             issue_extra;
	logic                             adv;
	logic                             set_extra;
	logic [lbp_pkg::PIXEL_W-1:0]      adv_pix;
	logic                             has;
	logic                             wrap;
	logic                             col_wrap;
	lbp_pkg::lbp_flags_t              adv_flags;

	// Config write and clamping of out-of-range geometry
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		width_nxt = cfg_data[lbp_pkg::CFG_WIDTH_W-1:0];
		if (width_nxt == '0) begin
			width_nxt = 12'd1;
		end else if (32'(width_nxt) > MAX_WIDTH) begin
			width_nxt = lbp_pkg::CFG_WIDTH_W'(MAX_WIDTH);
		end
		height_nxt = cfg_data[lbp_pkg::CFG_HEIGHT_W-1:0];
		if (height_nxt == '0) begin
			height_nxt = 13'd1;
		end else if (height_nxt > lbp_pkg::HEIGHT_LIMIT) begin
			height_nxt = lbp_pkg::HEIGHT_LIMIT;
		end
	end

	// Issue control: room for every transaction in flight plus this one
	assign room = ({1'b0, fifo_cnt} + {{lbp_pkg::OFIFO_CNT_W{1'b0}}, adv_s1}) <
		(lbp_pkg::OFIFO_CNT_W + 1)'(lbp_pkg::OFIFO_DEPTH);
	assign pix_stall   = clr_busy_q || extra_q || !room;
	assign accept      = pix_valid && !pix_stall;
	assign is_push     = (pix_item.action == lbp_pkg::ACT_PUSH);
	assign in_range    = (row_q < height_q);
	assign issue_extra = extra_q && room;
	assign adv         = issue_extra || (accept && (is_push ? in_range : !in_range));
	assign adv_pix     = (accept && is_push) ? pix_item.pixel : '0;
	// Drain of a one-row frame at the start of row one needs a second step
	assign set_extra   = accept && !is_push && !in_range && (row_q == 13'd1) &&
		(col_q == '0);

	// Which code this step completes and which neighbors lie inside the image
	assign has  = (row_q >= 13'd2) || ((row_q == 13'd1) && (col_q != '0));
	assign wrap = (col_q == '0) && has;

	always_comb begin
		adv_flags.emit   = has;
		adv_flags.last   = wrap && (row_q == height_q + 13'd1);
		adv_flags.top    = wrap ? (row_q >= 13'd3) : (row_q >= 13'd2);
		adv_flags.bottom = wrap ? (row_q <= height_q) : (row_q < height_q);
		adv_flags.left   = wrap ? (width_q >= 12'd2) : (col_q >= AW'(2));
		adv_flags.right  = !wrap;
	end

	assign col_wrap = (32'(col_q) + 32'd1) >= 32'(width_q);

	// Geometry, position and drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp_pkg::CFG_WIDTH_W'(WIDTH_RST);
			height_q <= lbp_pkg::HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
			extra_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lbp_pkg::REG_IMAGE_WIDTH: begin
						width_q <= width_nxt;
					end
					lbp_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= height_nxt;
					end
					default: begin
					end
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (adv) begin
				if (adv_flags.last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (col_wrap) begin
					row_q <= row_q + 13'd1;
					col_q <= '0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (set_extra) begin
				extra_q <= 1'b1;
			end else if (issue_extra) begin
				extra_q <= 1'b0;
			end
		end
	end

	// Clearing pass over the column store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_s1 <= 1'b0;
		end else begin
			adv_s1 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= col_q;
			pix_s1   <= adv_pix;
			flags_s1 <= adv_flags;
		end
	end

	// Column store: upper row in the high byte, middle row in the low byte
	lbp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_col_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (adv),
		.rd_addr(col_q),
		.rd_data(ram_rdata)
	);

	// Bypass the write of the previous cycle on the same column
	assign col_word  = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : ram_rdata;

	// Write back: middle moves up, the new pixel becomes the middle
	assign ram_we    = clr_busy_q || adv_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : {col_word[lbp_pkg::PIXEL_W-1:0], pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q <= ram_waddr;
			wr_data_q <= ram_wdata;
		end
	end

	// Window and compare
	lbp_code_unit u_code (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv_v    (adv_s1),
		.flags    (flags_s1),
		.col_up   (col_word[WORD_W-1:lbp_pkg::PIXEL_W]),
		.col_mid  (col_word[lbp_pkg::PIXEL_W-1:0]),
		.col_pix  (pix_s1),
		.code_v   (res_v),
		.code_item(res_item)
	);

	// Result queue
	lbp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_v),
		.push_item(res_item),
		.count    (fifo_cnt),
		.out_valid(code_valid),
		.out_stall(code_stall),
		.out_item (code_item)
	);

	// Final code of a frame returns the position to the frame start
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && adv_flags.last |=> (row_q == '0) && (col_q == '0))
		else $error("lbp core: no restart after the last code");

	// Column always lies inside the configured width
	a_col_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(width_q))
		else $error("lbp core: column beyond image width");

	// Draining never runs past the flush row
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) <= 32'(height_q) + 32'd1)
		else $error("lbp core: row beyond flush limit");

endmodule
